// ===== rtl/core/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

  localparam int LEVELS = 10;
  localparam int IDX_W  = 10;
  localparam int ORD_W  = 4;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  localparam int SLOTS  = 1 << IDX_W;
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int WRD_W  = IDX_W - BIT_W;
  localparam int SZ_W   = (1 << ORD_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOFREE = 2'd2,
    ST_ZERO   = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ORD_W-1:0] order;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] granted_index;
  } rsp_t;

  // words of one order's row of free bits
  function automatic logic [WRD_W:0] row_words(input logic [ORD_W-1:0] k);
    logic [IDX_W:0] n;
    n = (IDX_W + 1)'(SLOTS) >> k;
    if (n >= (IDX_W + 1)'(WORD_W)) begin
      return (WRD_W + 1)'(n >> BIT_W);
    end
    return (WRD_W + 1)'(1);
  endfunction

  function automatic int total_rows();
    int acc;
    acc = 0;
    for (int i = 0; i < LEVELS; i++) begin
      acc += int'(row_words(ORD_W'(i)));
    end
    return acc;
  endfunction

  localparam int ROWS = total_rows();
  localparam int RAW  = $clog2(ROWS);

  // first word of an order's row
  function automatic logic [RAW-1:0] row_base(input logic [ORD_W-1:0] k);
    int acc;
    acc = 0;
    for (int i = 0; i < LEVELS; i++) begin
      if (ORD_W'(i) < k) begin
        acc += int'(row_words(ORD_W'(i)));
      end
    end
    return RAW'(acc);
  endfunction

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INIT_LOAD,
    DP_INIT_STEP,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_SPLIT_RD,
    DP_SPLIT_WR,
    DP_MERGE_RD,
    DP_MERGE_CHK,
    DP_FINAL_RD,
    DP_FINAL_WR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctl_t;

  typedef struct packed {
    logic             k_zero;
    logic             hit;
    logic             scan_end;
    logic             split_done;
    logic             at_top;
    logic             buddy_set;
    logic             left_nz;
    logic             cfg_zero;
    logic [IDX_W-1:0] at;
  } sts_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bba_dp.sv =====
`timescale 1ns / 1ps

module bba_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bba_pkg::ctl_t              ctl_i,
  input  bba_pkg::req_t              req_i,
  input  logic                       cfg_we_i,
  input  logic [bba_pkg::IDX_W-1:0]  cfg_data_i,
  output bba_pkg::sts_t              sts_o
);

  localparam int IDX_W  = bba_pkg::IDX_W;
  localparam int ORD_W  = bba_pkg::ORD_W;
  localparam int BIT_W  = bba_pkg::BIT_W;
  localparam int WRD_W  = bba_pkg::WRD_W;
  localparam int SZ_W   = bba_pkg::SZ_W;
  localparam int RAW    = bba_pkg::RAW;
  localparam int ROWS   = bba_pkg::ROWS;
  localparam int WORD_W = bba_pkg::WORD_W;

  logic [IDX_W-1:0] cfg_q;
  logic [ORD_W-1:0] ord_q, k_q;
  logic [IDX_W-1:0] at_q, left_q, base_q;
  logic [WRD_W-1:0] wrd_q;
  logic [BIT_W-1:0] bit_q;
  logic [RAW-1:0]   raddr_q;
  logic             flag_q;
  logic [ROWS-1:0]  vld_q;
  logic             rvld_q;

  logic [WORD_W-1:0] rdata, rword, wdata;
  logic [RAW-1:0]    addr;
  logic              we;
  logic [SZ_W-1:0]   size, size_dn, buddy, up;
  logic [ORD_W-1:0]  k_dn;
  logic [IDX_W-1:0]  slot, slot_at, slot_base, slot_up;
  logic [BIT_W-1:0]  low;
  logic              hit, fits, wrd_last, buddy_set;

  assign size      = SZ_W'(1) << k_q;
  assign k_dn      = k_q - ORD_W'(1);
  assign size_dn   = SZ_W'(1) << k_dn;
  assign slot_at   = at_q >> k_q;
  assign slot_base = base_q >> k_q;
  assign slot_up   = (at_q >> k_dn) | IDX_W'(1);
  assign buddy     = SZ_W'(at_q) ^ size;
  assign up        = SZ_W'(at_q) + size_dn;
  assign rword     = rdata & {WORD_W{rvld_q}};
  assign hit       = |rword;
  assign fits      = SZ_W'(left_q) >= size;
  assign wrd_last  = (WRD_W + 1)'(wrd_q) == (bba_pkg::row_words(k_q) - (WRD_W + 1)'(1));
  assign buddy_set = flag_q && rword[bit_q];

  // lowest set bit of the word just read
  always_comb begin
    low = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (rword[i]) begin
        low = BIT_W'(i);
      end
    end
  end

  always_comb begin
    slot  = slot_at;
    addr  = bba_pkg::row_base(k_q) + RAW'(slot_at >> BIT_W);
    we    = 1'b0;
    wdata = rword;
    unique case (ctl_i.op)
      bba_pkg::DP_INIT_STEP: begin
        slot  = slot_base;
        addr  = bba_pkg::row_base(k_q) + RAW'(slot_base >> BIT_W);
        we    = fits;
        wdata = WORD_W'(1) << slot_base[BIT_W-1:0];
      end
      bba_pkg::DP_SCAN_RD: begin
        addr = bba_pkg::row_base(k_q) + RAW'(wrd_q);
      end
      bba_pkg::DP_SCAN_CHK: begin
        addr  = raddr_q;
        we    = hit;
        wdata = rword & ~(WORD_W'(1) << low);
      end
      bba_pkg::DP_SPLIT_RD: begin
        slot = slot_up;
        addr = bba_pkg::row_base(k_dn) + RAW'(slot_up >> BIT_W);
      end
      bba_pkg::DP_SPLIT_WR: begin
        addr  = raddr_q;
        we    = flag_q;
        wdata = rword | (WORD_W'(1) << bit_q);
      end
      bba_pkg::DP_MERGE_RD: begin
        slot = slot_at ^ IDX_W'(1);
        addr = bba_pkg::row_base(k_q) + RAW'((slot_at ^ IDX_W'(1)) >> BIT_W);
      end
      bba_pkg::DP_MERGE_CHK: begin
        addr  = raddr_q;
        we    = buddy_set;
        wdata = rword & ~(WORD_W'(1) << bit_q);
      end
      bba_pkg::DP_FINAL_WR: begin
        addr  = raddr_q;
        we    = 1'b1;
        wdata = rword | (WORD_W'(1) << bit_q);
      end
      default: begin
      end
    endcase
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // row valid bits: an unwritten row reads as nothing free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      cfg_q  <= '0;
    end else begin
      rvld_q <= vld_q[addr];
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (ctl_i.op == bba_pkg::DP_INIT_LOAD) begin
        vld_q <= '0;
      end else if (we) begin
        vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      bba_pkg::DP_LOAD: begin
        ord_q <= req_i.order;
        k_q   <= req_i.order;
        at_q  <= (req_i.block_index >> req_i.order) << req_i.order;
        wrd_q <= '0;
      end
      bba_pkg::DP_INIT_LOAD: begin
        k_q    <= ORD_W'(bba_pkg::LEVELS - 1);
        left_q <= cfg_q;
        base_q <= '0;
      end
      bba_pkg::DP_INIT_STEP: begin
        if (fits) begin
          base_q <= base_q + size[IDX_W-1:0];
          left_q <= left_q - size[IDX_W-1:0];
        end
        k_q <= k_dn;
      end
      bba_pkg::DP_SCAN_CHK: begin
        if (hit) begin
          at_q <= {wrd_q, low} << k_q;
        end else if (wrd_last) begin
          wrd_q <= '0;
          k_q   <= k_q + ORD_W'(1);
        end else begin
          wrd_q <= wrd_q + WRD_W'(1);
        end
      end
      bba_pkg::DP_SPLIT_RD: begin
        k_q     <= k_dn;
        flag_q  <= up < SZ_W'(bba_pkg::SLOTS);
        bit_q   <= slot[BIT_W-1:0];
        raddr_q <= addr;
      end
      bba_pkg::DP_MERGE_RD: begin
        flag_q  <= buddy < SZ_W'(bba_pkg::SLOTS);
        bit_q   <= slot[BIT_W-1:0];
        raddr_q <= addr;
      end
      bba_pkg::DP_MERGE_CHK: begin
        if (buddy_set) begin
          at_q <= at_q & ~size[IDX_W-1:0];
          k_q  <= k_q + ORD_W'(1);
        end
      end
      bba_pkg::DP_SCAN_RD, bba_pkg::DP_FINAL_RD: begin
        bit_q   <= slot[BIT_W-1:0];
        raddr_q <= addr;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.k_zero     = k_q == '0;
  assign sts_o.hit        = hit;
  assign sts_o.scan_end   = !hit && wrd_last && (k_q == ORD_W'(bba_pkg::LEVELS - 1));
  assign sts_o.split_done = k_q == ord_q;
  assign sts_o.at_top     = (ORD_W + 1)'(k_q) + (ORD_W + 1)'(1) >=
                            (ORD_W + 1)'(bba_pkg::LEVELS);
  assign sts_o.buddy_set  = buddy_set;
  assign sts_o.left_nz    = left_q != '0;
  assign sts_o.cfg_zero   = cfg_q == '0;
  assign sts_o.at         = at_q;

endmodule

// ===== rtl/core/bba_ctrl.sv =====
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bba_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bba_pkg::rsp_t  out_data_o,
  input  bba_pkg::sts_t  sts_i,
  output bba_pkg::ctl_t  ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_INIT_END,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_FINAL_RD,
    S_FINAL_WR,
    S_RESULT
  } state_e;

  state_e                      state_q;
  logic [bba_pkg::ST_W-1:0]    res_st_q;
  logic                        res_gnt_q;
  logic                        out_valid_q;
  bba_pkg::rsp_t               out_q;
  logic                        accept, ord_bad;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = state_q == S_IDLE;
  assign ord_bad    = (bba_pkg::ORD_W + 1)'(in_data_i.order) >=
                      (bba_pkg::ORD_W + 1)'(bba_pkg::LEVELS);

  always_comb begin
    ctl_o.op = bba_pkg::DP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.command == bba_pkg::CMD_INIT) begin
            if (!sts_i.cfg_zero) begin
              ctl_o.op = bba_pkg::DP_INIT_LOAD;
            end
          end else begin
            ctl_o.op = bba_pkg::DP_LOAD;
          end
        end
      end
      S_INIT:      ctl_o.op = bba_pkg::DP_INIT_STEP;
      S_SCAN_RD:   ctl_o.op = bba_pkg::DP_SCAN_RD;
      S_SCAN_CHK:  ctl_o.op = bba_pkg::DP_SCAN_CHK;
      S_SPLIT_RD:  ctl_o.op = bba_pkg::DP_SPLIT_RD;
      S_SPLIT_WR:  ctl_o.op = bba_pkg::DP_SPLIT_WR;
      S_MERGE_RD:  ctl_o.op = sts_i.at_top ? bba_pkg::DP_FINAL_RD : bba_pkg::DP_MERGE_RD;
      S_MERGE_CHK: ctl_o.op = bba_pkg::DP_MERGE_CHK;
      S_FINAL_RD:  ctl_o.op = bba_pkg::DP_FINAL_RD;
      S_FINAL_WR:  ctl_o.op = bba_pkg::DP_FINAL_WR;
      default:     ctl_o.op = bba_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_st_q    <= bba_pkg::ST_OK;
      res_gnt_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_gnt_q <= 1'b0;
            unique case (in_data_i.command)
              bba_pkg::CMD_INIT: begin
                if (sts_i.cfg_zero) begin
                  res_st_q <= bba_pkg::ST_ZERO;
                  state_q  <= S_RESULT;
                end else begin
                  state_q <= S_INIT;
                end
              end
              bba_pkg::CMD_ALLOC: begin
                res_st_q <= bba_pkg::ST_RANGE;
                state_q  <= ord_bad ? S_RESULT : S_SCAN_RD;
              end
              bba_pkg::CMD_FREE: begin
                res_st_q <= bba_pkg::ST_RANGE;
                state_q  <= ord_bad ? S_RESULT : S_MERGE_RD;
              end
              default: begin
                res_st_q <= bba_pkg::ST_RANGE;
                state_q  <= S_RESULT;
              end
            endcase
          end
        end
        S_INIT: begin
          if (sts_i.k_zero) begin
            state_q <= S_INIT_END;
          end
        end
        S_INIT_END: begin
          res_st_q <= sts_i.left_nz ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
          state_q  <= S_RESULT;
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (sts_i.hit) begin
            if (sts_i.split_done) begin
              res_st_q  <= bba_pkg::ST_OK;
              res_gnt_q <= 1'b1;
              state_q   <= S_RESULT;
            end else begin
              state_q <= S_SPLIT_RD;
            end
          end else if (sts_i.scan_end) begin
            res_st_q <= bba_pkg::ST_NOFREE;
            state_q  <= S_RESULT;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_SPLIT_RD: state_q <= S_SPLIT_WR;
        S_SPLIT_WR: begin
          if (sts_i.split_done) begin
            res_st_q  <= bba_pkg::ST_OK;
            res_gnt_q <= 1'b1;
            state_q   <= S_RESULT;
          end else begin
            state_q <= S_SPLIT_RD;
          end
        end
        S_MERGE_RD:  state_q <= sts_i.at_top ? S_FINAL_WR : S_MERGE_CHK;
        S_MERGE_CHK: state_q <= sts_i.buddy_set ? S_MERGE_RD : S_FINAL_RD;
        S_FINAL_RD:  state_q <= S_FINAL_WR;
        S_FINAL_WR: begin
          res_st_q <= bba_pkg::ST_OK;
          state_q  <= S_RESULT;
        end
        S_RESULT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_q.status        <= res_st_q;
            out_q.granted_index <= res_gnt_q ? sts_i.at : '0;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_ready_o  bba_pkg::req_t (command, order, block_index)
// out      output     out_valid_o/out_ready_i bba_pkg::rsp_t (status, granted_index)
// cfg      input      cfg_we_i               cfg_data_i (total_blocks)
//
// One item at a time; outside init, every free bit access is a read then a write of the free RAM port.
// Alloc: scans the rows from the order asked for upward, one 32-bit word at a time, then splits down.
// Free: merges with free buddies, then sets the merged block's bit; init: largest blocks first.
// Reset clears the row valid bits at once, so no clearing pass is needed.
// A new item is taken while the previous result waits in the output register.

module buddy_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bba_pkg::req_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bba_pkg::rsp_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::IDX_W-1:0] cfg_data_i
);

  bba_pkg::ctl_t ctl;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  bba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .req_i      (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts)
  );

endmodule
